// ----- design/tlsm_pkg.sv -----
// Package for the track lifecycle state machine.
// Holds item and configuration types, state and action codes, reset values.
// No dependencies.
`timescale 1ns / 1ps

package tlsm_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DETECT         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_LOST_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPOST_LOST_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_LOST_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP            = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OMNI_MODE          = 3'd5;

  // Configuration reset values
  localparam logic [7:0]  MIN_DETECT_RST         = 8'd3;
  localparam logic [7:0]  NORMAL_LOST_LIMIT_RST  = 8'd15;
  localparam logic [7:0]  OUTPOST_LOST_LIMIT_RST = 8'd75;
  localparam logic [7:0]  SWITCH_LOST_LIMIT_RST  = 8'd200;
  localparam logic [23:0] MAX_GAP_RST            = 24'd100000;

  // Track states
  localparam logic [2:0] ST_LOST      = 3'd0;
  localparam logic [2:0] ST_DETECTING = 3'd1;
  localparam logic [2:0] ST_TRACKING  = 3'd2;
  localparam logic [2:0] ST_TEMP_LOST = 3'd3;
  localparam logic [2:0] ST_SWITCHING = 3'd4;

  // Filter actions
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_INIT_MAIN = 2'd1;
  localparam logic [1:0] ACT_INIT_EXP  = 2'd2;
  localparam logic [1:0] ACT_PREDICT   = 2'd3;

  // Priority value used at reset
  localparam logic [2:0] PRIO_RST = 3'd5;

  typedef struct packed {
    logic [47:0] frame_time;
    logic        cand_found;
    logic [2:0]  cand_priority;
    logic        cand_outpost;
    logic        associated;
    logic        omni_found;
    logic [2:0]  omni_priority;
    logic        omni_outpost;
    logic        expected_seen;
    logic        converged;
    logic        diverged;
    logic        poor_quality;
  } tlsm_frame_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] track_state;
    logic       target_valid;
    logic [1:0] filter_action;
    logic       switch_request;
  } tlsm_result_t;

  typedef struct packed {
    logic [7:0]  min_detect;
    logic [7:0]  normal_lost_limit;
    logic [7:0]  outpost_lost_limit;
    logic [7:0]  switch_lost_limit;
    logic [23:0] max_gap;
    logic        omni_mode;
  } tlsm_cfg_t;

  // Increment that sticks at 255
  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

// ----- design/tlsm_if.sv -----
// Valid/ready channel interfaces for frame items and result items.
// Depends on tlsm_pkg.
`timescale 1ns / 1ps

interface tlsm_frame_if;
  import tlsm_pkg::*;
  logic        valid;
  logic        ready;
  tlsm_frame_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tlsm_result_if;
  import tlsm_pkg::*;
  logic         valid;
  logic         ready;
  tlsm_result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/track_lifecycle_state_machine.sv -----
// Track lifecycle state machine: top level with input and result registers.
// A frame item enters on the frame channel, its result leaves on the result channel.
// Configuration goes through a plain write port: cfg_we, cfg_index, cfg_data.
// Register index order: min_detect, normal_lost_limit, outpost_lost_limit,
// switch_lost_limit, max_gap, omni_mode.
// Every frame item gives exactly one result item; a frame whose time is not
// newer than the last accepted one comes back with accepted low and no change.
// An accepted item is held in the input register and then moves into the
// result register, from which it shows on the result channel.
// Throughput: one item per cycle while the receiver takes results; the whole
// state update is one pass of logic between the input and result registers.
// Reset (rst, synchronous) clears the track to lost, loads the configuration
// defaults and empties both registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; further items wait until the result is taken.
// Depends on tlsm_pkg, tlsm_if, tlsm_cfg_regs and tlsm_core.
`timescale 1ns / 1ps

module track_lifecycle_state_machine
  import tlsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  tlsm_frame_if.sink            frame,
  tlsm_result_if.source         result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tlsm_cfg_t    cfg;
  logic         frame_v;
  tlsm_frame_t  frame_q;
  logic         res_v;
  tlsm_result_t res_q;
  tlsm_result_t core_res;
  logic         advance;

  tlsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move the held item into the result register when there is room
  assign advance     = frame_v && (!res_v || result.ready);
  assign frame.ready = !frame_v || advance;

  tlsm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (advance),
    .item (frame_q),
    .res  (core_res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_v <= 1'b0;
    end else if (frame.valid && frame.ready) begin
      frame_v <= 1'b1;
    end else if (advance) begin
      frame_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) frame_q <= frame.payload;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (advance) begin
      res_v <= 1'b1;
    end else if (result.ready) begin
      res_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_q <= core_res;
  end

  assign result.valid   = res_v;
  assign result.payload = res_q;

endmodule

// ----- design/tlsm_cfg_regs.sv -----
// Configuration register file for the track state machine.
// Depends on tlsm_pkg.
`timescale 1ns / 1ps

module tlsm_cfg_regs
  import tlsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output tlsm_cfg_t             cfg
);

  // Write one register per enabled cycle; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_detect         <= MIN_DETECT_RST;
      cfg.normal_lost_limit  <= NORMAL_LOST_LIMIT_RST;
      cfg.outpost_lost_limit <= OUTPOST_LOST_LIMIT_RST;
      cfg.switch_lost_limit  <= SWITCH_LOST_LIMIT_RST;
      cfg.max_gap            <= MAX_GAP_RST;
      cfg.omni_mode          <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_DETECT:         cfg.min_detect         <= cfg_data[7:0];
        CFG_NORMAL_LOST_LIMIT:  cfg.normal_lost_limit  <= cfg_data[7:0];
        CFG_OUTPOST_LOST_LIMIT: cfg.outpost_lost_limit <= cfg_data[7:0];
        CFG_SWITCH_LOST_LIMIT:  cfg.switch_lost_limit  <= cfg_data[7:0];
        CFG_MAX_GAP:            cfg.max_gap            <= cfg_data;
        CFG_OMNI_MODE:          cfg.omni_mode          <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/tlsm_core.sv -----
// Track state registers and the single-pass next-state logic for one frame.
// Depends on tlsm_pkg.
`timescale 1ns / 1ps

module tlsm_core
  import tlsm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  tlsm_cfg_t    cfg,
  input  logic         fire,
  input  tlsm_frame_t  item,
  output tlsm_result_t res
);

  // Track state
  logic [2:0]  mode_state;
  logic [7:0]  detect_counter;
  logic [7:0]  lost_counter;
  logic [47:0] last_time;
  logic        time_seen;
  logic [2:0]  target_priority;
  logic        target_is_outpost;
  logic [2:0]  pending_priority;
  logic        pending_outpost;

  logic [2:0]  mode_state_next;
  logic [7:0]  detect_counter_next;
  logic [7:0]  lost_counter_next;
  logic        time_seen_next;
  logic [2:0]  target_priority_next;
  logic        target_is_outpost_next;
  logic [2:0]  pending_priority_next;
  logic        pending_outpost_next;

  // Intermediate values
  logic        stale;
  logic [47:0] gap;
  logic [2:0]  st_gap;
  logic [2:0]  st_adv;
  logic [1:0]  action;
  logic        sw;
  logic        found;
  logic [7:0]  det_inc;
  logic [7:0]  lost_inc;
  logic [7:0]  limit;

  assign stale = time_seen && (item.frame_time <= last_time);
  assign gap   = item.frame_time - last_time;

  always_comb begin
    mode_state_next        = mode_state;
    detect_counter_next    = detect_counter;
    lost_counter_next      = lost_counter;
    time_seen_next         = time_seen;
    target_priority_next   = target_priority;
    target_is_outpost_next = target_is_outpost;
    pending_priority_next  = pending_priority;
    pending_outpost_next   = pending_outpost;
    action                 = ACT_NONE;
    sw                     = 1'b0;
    found                  = 1'b0;
    st_gap                 = mode_state;
    st_adv                 = mode_state;
    det_inc                = 8'd0;
    lost_inc               = 8'd0;
    limit                  = 8'd0;

    if (!stale) begin
      time_seen_next = 1'b1;

      // Drop a live track across a long time gap
      if (mode_state != ST_LOST && gap > {24'd0, cfg.max_gap}) begin
        st_gap = ST_LOST;
      end
      st_adv = st_gap;

      // Choose the filter action for this frame
      if (st_gap == ST_LOST) begin
        if (item.cand_found) begin
          action = ACT_INIT_MAIN;
          found  = 1'b1;
        end
      end else if (cfg.omni_mode && st_gap == ST_TRACKING && item.cand_found &&
                   item.cand_priority < target_priority) begin
        st_adv = ST_LOST;
        action = ACT_INIT_MAIN;
        found  = 1'b1;
      end else if (cfg.omni_mode && st_gap == ST_TRACKING && item.omni_found &&
                   item.omni_priority < target_priority && item.converged) begin
        st_adv                = ST_SWITCHING;
        lost_counter_next     = 8'd0;
        detect_counter_next   = 8'd0;
        pending_priority_next = item.omni_priority;
        pending_outpost_next  = item.omni_outpost;
        sw                    = 1'b1;
      end else if (cfg.omni_mode && st_gap == ST_SWITCHING) begin
        if (item.expected_seen) begin
          action = ACT_INIT_EXP;
          found  = 1'b1;
        end
      end else begin
        action = ACT_PREDICT;
        found  = item.associated;
      end

      // Latch the target identity on a filter init
      if (action == ACT_INIT_MAIN) begin
        target_priority_next   = item.cand_priority;
        target_is_outpost_next = item.cand_outpost;
      end else if (action == ACT_INIT_EXP) begin
        target_priority_next   = pending_priority;
        target_is_outpost_next = pending_outpost;
      end

      det_inc  = sat_inc(detect_counter_next);
      lost_inc = sat_inc(lost_counter_next);
      limit    = target_is_outpost_next ? cfg.outpost_lost_limit
                                        : cfg.normal_lost_limit;
      mode_state_next = st_adv;

      // Advance the lifecycle
      case (st_adv)
        ST_LOST: begin
          if (found) begin
            detect_counter_next = 8'd1;
            lost_counter_next   = 8'd0;
            mode_state_next     = (cfg.min_detect <= 8'd1) ? ST_TRACKING : ST_DETECTING;
          end
        end
        ST_DETECTING: begin
          if (found) begin
            detect_counter_next = det_inc;
            if (det_inc >= cfg.min_detect) mode_state_next = ST_TRACKING;
          end else begin
            detect_counter_next = 8'd0;
            mode_state_next     = ST_LOST;
          end
        end
        ST_TRACKING: begin
          if (!found) begin
            lost_counter_next = 8'd1;
            mode_state_next   = ST_TEMP_LOST;
          end
        end
        ST_SWITCHING: begin
          if (found) begin
            detect_counter_next = 8'd1;
            lost_counter_next   = 8'd0;
            mode_state_next     = (cfg.min_detect <= 8'd1) ? ST_TRACKING : ST_DETECTING;
          end else begin
            lost_counter_next = lost_inc;
            if (lost_inc > cfg.switch_lost_limit) mode_state_next = ST_LOST;
          end
        end
        ST_TEMP_LOST: begin
          if (found) begin
            lost_counter_next = 8'd0;
            mode_state_next   = ST_TRACKING;
          end else begin
            lost_counter_next = lost_inc;
            if (lost_inc > limit) mode_state_next = ST_LOST;
          end
        end
        default: mode_state_next = ST_LOST;
      endcase

      // Filter health drops the track; poor quality is ignored while switching in omni mode
      if (item.diverged) mode_state_next = ST_LOST;
      if (item.poor_quality && !(cfg.omni_mode && mode_state_next == ST_SWITCHING)) begin
        mode_state_next = ST_LOST;
      end
    end
  end

  // Result for this frame
  always_comb begin
    res.accepted       = !stale;
    res.track_state    = mode_state_next;
    res.target_valid   = !stale && (mode_state_next != ST_LOST);
    res.filter_action  = action;
    res.switch_request = sw;
  end

  // Commit the state on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state        <= ST_LOST;
      detect_counter    <= 8'd0;
      lost_counter      <= 8'd0;
      last_time         <= 48'd0;
      time_seen         <= 1'b0;
      target_priority   <= PRIO_RST;
      target_is_outpost <= 1'b0;
      pending_priority  <= PRIO_RST;
      pending_outpost   <= 1'b0;
    end else if (fire) begin
      mode_state        <= mode_state_next;
      detect_counter    <= detect_counter_next;
      lost_counter      <= lost_counter_next;
      time_seen         <= time_seen_next;
      target_priority   <= target_priority_next;
      target_is_outpost <= target_is_outpost_next;
      pending_priority  <= pending_priority_next;
      pending_outpost   <= pending_outpost_next;
      if (!stale) last_time <= item.frame_time;
    end
  end

endmodule

// ----- design/tlsm_checker.sv -----
// Port-level checks on the result channel of the track state machine.
// Depends on tlsm_pkg; bound to track_lifecycle_state_machine.
`timescale 1ns / 1ps

module tlsm_checker
  import tlsm_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         valid,
  input logic         ready,
  input tlsm_result_t pl
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(pl))
    else $error("result changed while stalled");

  // Target valid follows the final state
  a_tvalid: assert property (@(posedge clk) disable iff (rst)
    valid && pl.accepted |-> pl.target_valid == (pl.track_state != ST_LOST))
    else $error("target_valid disagrees with track_state");

  // A rejected frame does nothing
  a_reject: assert property (@(posedge clk) disable iff (rst)
    valid && !pl.accepted |->
      !pl.target_valid && pl.filter_action == ACT_NONE && !pl.switch_request)
    else $error("rejected frame shows activity");

  // A switch never comes with a filter init
  a_switch: assert property (@(posedge clk) disable iff (rst)
    valid && pl.switch_request |-> pl.accepted && pl.filter_action == ACT_NONE)
    else $error("switch issued together with a filter action");

  // Init from the main candidate ends in lost, detecting or tracking
  a_init: assert property (@(posedge clk) disable iff (rst)
    valid && pl.filter_action == ACT_INIT_MAIN |->
      pl.track_state == ST_LOST || pl.track_state == ST_DETECTING ||
      pl.track_state == ST_TRACKING)
    else $error("main init left an unexpected state");

endmodule

bind track_lifecycle_state_machine tlsm_checker u_tlsm_checker (
  .clk   (clk),
  .rst   (rst),
  .valid (result.valid),
  .ready (result.ready),
  .pl    (result.payload)
);
